// ===== sv/stbs_pkg.sv =====
// shared types and constants of the sorted table search block
package stbs_pkg;

    localparam int KEY_W = 16;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;
    localparam int IDX_W = 5;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== sv/stbs_ram.sv =====
// generic single write port ram with registered read
module stbs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/stbs_cmp.sv =====
// shared key compare unit used by both sort and search
module stbs_cmp (
    input  stbs_pkg::key_t     op_a,
    input  stbs_pkg::key_t     op_b,
    output stbs_pkg::cmp_res_t res
);

    always_comb
    begin
        res.gt = (op_a > op_b);
        res.eq = (op_a == op_b);
    end

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// top level: key table with in-place exchange sort and binary search
//
// channel   signals                           direction  notes
// command   start, busy, cmd, position, key   in         item taken when start & !busy
// result    result_valid, found, index        out        one-cycle strobe, no back pressure
// config    cfg_valid, cfg_ready, cfg_data    in         entry_count, ready always high
//
// a load item does not raise busy; its result strobes in the cycle after it is taken.
// a search over n entries sorts the table in place (no sort for n < 2), then runs
// a binary search, each probe passing ST_ADDR then ST_PROBE, a miss closing in ST_ADDR;
// its result strobes in the first cycle with busy low again. the single ram read port
// and the one shared comparator set this step by step schedule.
// rst_n clears control and entry_count; table contents stay undefined until loaded.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cmd,
    input  logic [stbs_pkg::POS_W-1:0] position,
    input  logic [stbs_pkg::KEY_W-1:0] key,
    output logic                      result_valid,
    output logic                      found,
    output logic [stbs_pkg::IDX_W-1:0] index,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [stbs_pkg::CNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CAP   = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_PROBE = 3'd5;

    logic [2:0] state_reg, state_next;
    stbs_pkg::cnt_t entry_count_reg;
    stbs_pkg::cnt_t n_reg, n_next;
    stbs_pkg::cnt_t i_reg, i_next;
    stbs_pkg::cnt_t j_reg, j_next;
    stbs_pkg::cnt_t lo_reg, lo_next;
    stbs_pkg::cnt_t hip_reg, hip_next;
    stbs_pkg::cnt_t mid_reg, mid_next;
    stbs_pkg::key_t cur_reg, cur_next;
    stbs_pkg::key_t key_reg, key_next;
    logic result_valid_reg, result_valid_next;
    logic found_reg, found_next;
    logic [stbs_pkg::IDX_W-1:0] index_reg, index_next;

    logic                we;
    logic [AW-1:0]       waddr;
    stbs_pkg::key_t      wdata;
    logic [AW-1:0]       raddr;
    stbs_pkg::key_t      rdata;
    stbs_pkg::key_t      op_a;
    stbs_pkg::key_t      op_b;
    stbs_pkg::cmp_res_t  cmp;
    stbs_pkg::cnt_t      n_clamp;
    logic [stbs_pkg::CNT_W:0] mid_sum;
    stbs_pkg::cnt_t      mid_calc;

    stbs_ram #(
        .DATA_W (stbs_pkg::KEY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    stbs_cmp u_cmp (
        .op_a (op_a),
        .op_b (op_b),
        .res  (cmp)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign index        = index_reg;

    assign n_clamp  = (32'(entry_count_reg) > TABLE_DEPTH) ?
                      stbs_pkg::CNT_W'(TABLE_DEPTH) : entry_count_reg;
    assign mid_sum  = (stbs_pkg::CNT_W+1)'(lo_reg) + (stbs_pkg::CNT_W+1)'(hip_reg)
                      - (stbs_pkg::CNT_W+1)'(1);
    assign mid_calc = mid_sum[stbs_pkg::CNT_W:1];

    // shared comparator: sort compares held key against table, search compares table
    // against the wanted key
    always_comb
    begin
        if (state_reg == ST_PROBE)
        begin
            op_a = rdata;
            op_b = key_reg;
        end
        else
        begin
            op_a = cur_reg;
            op_b = rdata;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        lo_next           = lo_reg;
        hip_next          = hip_reg;
        mid_next          = mid_reg;
        cur_next          = cur_reg;
        key_next          = key_reg;
        result_valid_next = 1'b0;
        found_next        = found_reg;
        index_next        = index_reg;
        we                = 1'b0;
        waddr             = AW'(i_reg);
        wdata             = cur_reg;
        raddr             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    if (cmd == stbs_pkg::CMD_LOAD)
                    begin
                        we                = (32'(position) < TABLE_DEPTH);
                        waddr             = AW'(position);
                        wdata             = key;
                        result_valid_next = 1'b1;
                        found_next        = 1'b0;
                        index_next        = position;
                    end
                    else
                    begin
                        n_next   = n_clamp;
                        i_next   = '0;
                        lo_next  = '0;
                        hip_next = n_clamp;
                        if (n_clamp > stbs_pkg::CNT_W'(1))
                        begin
                            state_next = ST_CAP;
                        end
                        else
                        begin
                            state_next = ST_ADDR;
                        end
                    end
                end
            end
            ST_CAP:
            begin
                // slot i arrives; start sweeping the later slots
                cur_next   = rdata;
                raddr      = AW'(i_reg + stbs_pkg::CNT_W'(1));
                j_next     = i_reg + stbs_pkg::CNT_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (cmp.gt)
                begin
                    we       = 1'b1;
                    waddr    = AW'(j_reg);
                    wdata    = cur_reg;
                    cur_next = rdata;
                end
                if ((j_reg + stbs_pkg::CNT_W'(1)) == n_reg)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    raddr  = AW'(j_reg + stbs_pkg::CNT_W'(1));
                    j_next = j_reg + stbs_pkg::CNT_W'(1);
                end
            end
            ST_WB:
            begin
                // smallest remaining key settles in slot i
                we    = 1'b1;
                waddr = AW'(i_reg);
                wdata = cur_reg;
                raddr = AW'(i_reg + stbs_pkg::CNT_W'(1));
                if (((stbs_pkg::CNT_W+1)'(i_reg) + (stbs_pkg::CNT_W+1)'(2))
                    < (stbs_pkg::CNT_W+1)'(n_reg))
                begin
                    i_next     = i_reg + stbs_pkg::CNT_W'(1);
                    state_next = ST_CAP;
                end
                else
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (lo_reg < hip_reg)
                begin
                    raddr      = AW'(mid_calc);
                    mid_next   = mid_calc;
                    state_next = ST_PROBE;
                end
                else
                begin
                    result_valid_next = 1'b1;
                    found_next        = 1'b0;
                    index_next        = '0;
                    state_next        = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (cmp.eq)
                begin
                    result_valid_next = 1'b1;
                    found_next        = 1'b1;
                    index_next        = stbs_pkg::IDX_W'(mid_reg);
                    state_next        = ST_IDLE;
                end
                else if (cmp.gt)
                begin
                    hip_next   = mid_reg;
                    state_next = ST_ADDR;
                end
                else
                begin
                    lo_next    = mid_reg + stbs_pkg::CNT_W'(1);
                    state_next = ST_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_count_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        lo_reg    <= lo_next;
        hip_reg   <= hip_next;
        mid_reg   <= mid_next;
        cur_reg   <= cur_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        index_reg <= index_next;
    end

endmodule

// ===== tb/sv/tb_sorted_table_binary_search.sv =====
// testbench for sorted_table_binary_search: directed table plus random load/search phases
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;

    localparam int DEPTH      = 32;
    localparam int ITEM_GOAL  = 1170;
    localparam int DRAIN_MAX  = 5000;
    localparam int TAIL_WAIT  = 20;
    localparam int PLAN_LEN   = 17;

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::IDX_W-1:0] index;
    } answer_t;

    typedef struct {
        bit                         is_cfg;
        logic                       c;
        logic [stbs_pkg::POS_W-1:0] pos;
        logic [stbs_pkg::KEY_W-1:0] k;
        logic [stbs_pkg::CNT_W-1:0] cnt;
        bit                         typed;
        answer_t                    exp;
    } plan_row_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       cmd = stbs_pkg::CMD_LOAD;
    logic [stbs_pkg::POS_W-1:0] position = '0;
    logic [stbs_pkg::KEY_W-1:0] key = '0;
    logic                       result_valid;
    logic                       found;
    logic [stbs_pkg::IDX_W-1:0] index;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [stbs_pkg::CNT_W-1:0] cfg_data = '0;

    // tags that travel with the item on the command port
    bit               tag_typed = 1'b0;
    answer_t          tag_answer = '0;

    // predictor state
    logic [stbs_pkg::KEY_W-1:0] key_table [DEPTH];
    logic [stbs_pkg::CNT_W-1:0] entries_used = '0;
    answer_t                    pending_answers [$];

    bit gaps_on = 1'b1;
    int errors = 0;
    int n_items = 0;
    int n_loads = 0;
    int n_searches = 0;
    int n_hits = 0;
    int n_cfg = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .position     (position),
        .key          (key),
        .result_valid (result_valid),
        .found        (found),
        .index        (index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic answer_t sort_and_lookup(logic c, logic [stbs_pkg::POS_W-1:0] p,
                                                logic [stbs_pkg::KEY_W-1:0] k);
        answer_t                    a;
        int                         n;
        int                         lo;
        int                         hi;
        int                         mid;
        logic [stbs_pkg::KEY_W-1:0] t;
        a = '0;
        if (c == stbs_pkg::CMD_LOAD)
        begin
            key_table[p] = k;
            a.index = p;
        end
        else
        begin
            n = (entries_used > DEPTH) ? DEPTH : int'(entries_used);
            for (int i = 0; i + 1 < n; i++)
            begin
                for (int j = i + 1; j < n; j++)
                begin
                    if (key_table[i] > key_table[j])
                    begin
                        t = key_table[i];
                        key_table[i] = key_table[j];
                        key_table[j] = t;
                    end
                end
            end
            lo = 0;
            hi = n - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (key_table[mid] == k)
                begin
                    a.found = 1'b1;
                    a.index = mid[stbs_pkg::IDX_W-1:0];
                    break;
                end
                else if (key_table[mid] > k)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        return a;
    endfunction

    // accepted items, config writes and result checks, in edge order
    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: result with no item pending: found %0d index %0d",
                             $time, found, index);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0d actual %0d",
                                 $time, want.found, found);
                        errors++;
                    end
                    if (index !== want.index)
                    begin
                        $display("%0t: index mismatch: expected %0d actual %0d",
                                 $time, want.index, index);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                entries_used = cfg_data;
            if (start && !busy)
            begin
                got = sort_and_lookup(cmd, position, key);
                pending_answers.push_back(tag_typed ? tag_answer : got);
                if (cmd == stbs_pkg::CMD_LOAD)
                    n_loads++;
                else
                begin
                    n_searches++;
                    if (got.found)
                        n_hits++;
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [stbs_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return stbs_pkg::KEY_W'($urandom_range(0, 15));
        return stbs_pkg::KEY_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_item(logic c, logic [stbs_pkg::POS_W-1:0] p,
                             logic [stbs_pkg::KEY_W-1:0] k, bit typed, answer_t ans);
        int gap;
        gap = gap_len();
        start      <= 1'b1;
        cmd        <= c;
        position   <= p;
        key        <= k;
        tag_typed  <= typed;
        tag_answer <= ans;
        do
            @(posedge clk);
        while (busy);
        n_items++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_answers.size() != 0 || busy);
    endtask

    task automatic write_count(logic [stbs_pkg::CNT_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin
        plan_row_t                  plan [PLAN_LEN];
        int                         ph;
        int                         r;
        int                         cnt;
        int                         n;
        int                         n_ld;
        int                         n_sr;
        bit                         mixed;
        bit                         is_load;
        logic [stbs_pkg::POS_W-1:0] p;
        logic [stbs_pkg::KEY_W-1:0] k;
        int                         waited;

        plan = '{
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd0,  16'h1234, 6'd0, 1'b1, '{1'b0, 5'd0}},  // empty table
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd0,  16'hFFFF, 6'd0, 1'b1, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd31, 16'h0000, 6'd0, 1'b1, '{1'b0, 5'd31}},
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd1,  16'h8000, 6'd0, 1'b1, '{1'b0, 5'd1}},
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd2,  16'h0001, 6'd0, 1'b1, '{1'b0, 5'd2}},
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd3,  16'h8000, 6'd0, 1'b1, '{1'b0, 5'd3}},
            '{1'b1, stbs_pkg::CMD_LOAD,   5'd0,  16'h0000, 6'd1, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd31, 16'hFFFF, 6'd0, 1'b1, '{1'b1, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd0,  16'h0000, 6'd0, 1'b1, '{1'b0, 5'd0}},  // miss
            '{1'b1, stbs_pkg::CMD_LOAD,   5'd0,  16'h0000, 6'd4, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd21, 16'h8000, 6'd0, 1'b0, '{1'b0, 5'd0}},  // duplicates
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd22, 16'h0001, 6'd0, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd10, 16'hFFFF, 6'd0, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd0,  16'h0002, 6'd0, 1'b1, '{1'b0, 5'd0}},  // miss
            '{1'b1, stbs_pkg::CMD_LOAD,   5'd0,  16'h0000, 6'd2, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_SEARCH, 5'd0,  16'h8000, 6'd0, 1'b0, '{1'b0, 5'd0}},
            '{1'b0, stbs_pkg::CMD_LOAD,   5'd30, 16'h5A5A, 6'd0, 1'b1, '{1'b0, 5'd30}}
        };
        foreach (key_table[i])
            key_table[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_count(plan[i].cnt);
            else
                send_item(plan[i].c, plan[i].pos, plan[i].k, plan[i].typed, plan[i].exp);
        end

        // fill every slot so any entry_count is legal from here on
        for (int i = 0; i < DEPTH; i++)
            send_item(stbs_pkg::CMD_LOAD, stbs_pkg::POS_W'(i), pick_key(), 1'b0, '0);

        ph = 0;
        while (n_items < ITEM_GOAL)
        begin
            r = $urandom_range(0, 99);
            case (ph)
                0: cnt = 32;
                1: cnt = 0;
                2: cnt = 63;
                3: cnt = 33;
                default:
                begin
                    if (r < 5)
                        cnt = 0;
                    else if (r < 65)
                        cnt = $urandom_range(1, 8);
                    else if (r < 92)
                        cnt = $urandom_range(9, 31);
                    else if (r < 96)
                        cnt = 32;
                    else
                        cnt = $urandom_range(33, 63);
                end
            endcase
            n = (cnt > DEPTH) ? DEPTH : cnt;
            gaps_on = ($urandom_range(0, 3) != 0);
            write_count(stbs_pkg::CNT_W'(cnt));
            n_ld = $urandom_range(0, 4);
            n_sr = $urandom_range(3, 12);
            mixed = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < n_ld + n_sr; i++)
            begin
                is_load = mixed ? bit'($urandom_range(0, 1)) : (i < n_ld);
                if (n > 0 && $urandom_range(0, 3) != 0)
                    p = stbs_pkg::POS_W'($urandom_range(0, n - 1));
                else
                    p = stbs_pkg::POS_W'($urandom_range(0, DEPTH - 1));
                if (!is_load && n > 0 && $urandom_range(0, 9) < 6)
                    k = key_table[$urandom_range(0, n - 1)];
                else
                    k = pick_key();
                send_item(is_load ? stbs_pkg::CMD_LOAD : stbs_pkg::CMD_SEARCH, p, k,
                          1'b0, '0);
            end
            ph++;
        end

        start <= 1'b0;
        waited = 0;
        while ((pending_answers.size() != 0 || busy) && waited < DRAIN_MAX)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
            errors++;
        end

        $display("run covered %0d loads and %0d searches (%0d hits, %0d misses)",
                 n_loads, n_searches, n_hits, n_searches - n_hits);
        $display("across %0d entry_count writes in %0d phases, %0d errors",
                 n_cfg, ph, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
